@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define VDR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("vertex_dedup_remap: assertion failed");

// Condition must never be seen outside reset.
`define VDR_NEVER(lbl, clk, rstn, cond) `VDR_ASSERT(lbl, clk, rstn, !(cond))

`endif

@@ rtl/core/vdr_pkg.sv @@
// ----------------------------------------------------------------------------
// vdr_pkg
// Shared constants, codes and types of the vertex dedup / remap block.
// ----------------------------------------------------------------------------
package vdr_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int WORD_W       = 32;
    localparam int COORD_W      = 16;
    localparam int KIND_W       = 2;
    localparam int S_DATA_W     = 48;
    localparam int M_DATA_W     = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_REMAP = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_REMAP,
        ST_EMIT
    } state_t;

    typedef enum logic {
        US_IDLE,
        US_SCAN
    } uscan_t;

    typedef struct packed {
        logic              start;
        logic              clear;
        logic [WORD_W-1:0] word;
    } uniq_req_t;

    typedef struct packed {
        logic             done;
        logic             fresh;
        logic [IDX_W-1:0] index;
        logic [CNT_W-1:0] count;
    } uniq_rsp_t;

endpackage

@@ rtl/core/vdr_uniq.sv @@
// ----------------------------------------------------------------------------
// vdr_uniq
// Unique vertex store with a linear first-match scan and append on miss.
// ----------------------------------------------------------------------------
module vdr_uniq
    import vdr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  uniq_req_t req,
    output uniq_rsp_t rsp
);

    logic [WORD_W-1:0] store_mem [MAX_VERTICES];

    uscan_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_addr_reg, rd_addr_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]  cmp_addr_reg, cmp_addr_next;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              hit, miss, rd_en;

    // read data of address N is compared in the cycle after the read is issued
    assign hit   = (state_reg == US_SCAN) && cmp_valid_reg && (rd_data_reg == word_reg);
    assign miss  = (state_reg == US_SCAN) && !cmp_valid_reg && (rd_addr_reg >= count_reg);
    assign rd_en = (state_reg == US_SCAN) && !hit && (rd_addr_reg < count_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            US_IDLE: begin
                if (req.start) begin
                    state_next = US_SCAN;
                end
            end
            US_SCAN: begin
                if (hit || miss) begin
                    state_next = US_IDLE;
                end
            end
            default: state_next = US_IDLE;
        endcase
    end

    always_comb begin
        cmp_valid_next = rd_en;
        cmp_addr_next  = rd_addr_reg[IDX_W-1:0];
        rd_addr_next   = rd_addr_reg;
        count_next     = count_reg;
        if (state_reg == US_IDLE) begin
            rd_addr_next = '0;
        end else if (rd_en) begin
            rd_addr_next = rd_addr_reg + 1'b1;
        end
        if (req.clear) begin
            count_next = '0;
        end else if (miss) begin
            count_next = count_reg + 1'b1;
        end
        rsp.done  = hit || miss;
        rsp.fresh = miss;
        rsp.index = hit ? cmp_addr_reg : count_reg[IDX_W-1:0];
        rsp.count = count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= US_IDLE;
            count_reg     <= '0;
            rd_addr_reg   <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_addr_reg   <= rd_addr_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_addr_reg <= cmp_addr_next;
        if (req.start) begin
            word_reg <= req.word;
        end
    end

    always_ff @(posedge aclk) begin
        if (miss) begin
            store_mem[count_reg[IDX_W-1:0]] <= word_reg;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr_reg[IDX_W-1:0]];
        end
    end

endmodule

@@ rtl/core/vertex_dedup_remap.sv @@
// ----------------------------------------------------------------------------
// vertex_dedup_remap
// Removes duplicate vertices and translates original indices to compact ones.
// ----------------------------------------------------------------------------
// Input stream s_*: one request per item, kind in s_tuser. A clear request
// empties both tables, a load request looks the x,y word up in the unique
// store and appends it when new, a remap request translates an original
// vertex index through the remap table. Every request yields exactly one
// result on m_*: compact index in m_tdata, is_new and error in m_tuser.
// The block works on one request at a time. A load scans the unique store
// through its single read port, one entry per cycle, and stops at the first
// match. The result sits in an output register; while the receiver stalls,
// one more request may be accepted and processed, then s_tready stays low
// until the output register frees up.
// Reset empties both tables at once (counts to zero); the stores need no
// clearing pass since only entries below the counts are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_dedup_remap
    import vdr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // vertex_x[15:0], vertex_y[31:16], endpoint_index[43:32]
    input  logic [KIND_W-1:0]   s_tuser,   // kind[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // compact_index[11:0]
    output logic [1:0]          m_tuser    // is_new[0], error[1]
);

    logic [IDX_W-1:0] remap_mem [MAX_VERTICES];

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] loaded_count_reg, loaded_count_next;
    logic [IDX_W-1:0] res_index_reg, res_index_next;
    logic             res_new_reg, res_new_next;
    logic             res_err_reg, res_err_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [IDX_W-1:0] m_index_reg, m_index_next;
    logic             m_new_reg, m_new_next;
    logic             m_err_reg, m_err_next;
    logic [IDX_W-1:0] remap_rd_reg;

    kind_t            in_kind;
    logic [IDX_W-1:0] in_ep;
    logic             s_accept, full, ep_ok, out_free, remap_rd_en, remap_wr_en;
    uniq_req_t        uniq_req;
    uniq_rsp_t        uniq_rsp;

    assign in_kind  = kind_t'(s_tuser);
    assign in_ep    = s_tdata[2*COORD_W +: IDX_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign full     = loaded_count_reg >= CNT_W'(MAX_VERTICES);
    assign ep_ok    = {1'b0, in_ep} < loaded_count_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign remap_rd_en = s_accept && (in_kind == KIND_REMAP) && ep_ok;
    assign remap_wr_en = (state_reg == ST_SEARCH) && uniq_rsp.done;

    assign uniq_req.start = s_accept && (in_kind == KIND_LOAD) && !full;
    assign uniq_req.clear = s_accept && (in_kind == KIND_CLEAR);
    assign uniq_req.word  = s_tdata[WORD_W-1:0];

    vdr_uniq u_uniq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (uniq_req),
        .rsp     (uniq_rsp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (in_kind)
                        KIND_LOAD:  state_next = full ? ST_EMIT : ST_SEARCH;
                        KIND_REMAP: state_next = ep_ok ? ST_REMAP : ST_EMIT;
                        default:    state_next = ST_EMIT;
                    endcase
                end
            end
            ST_SEARCH: begin
                if (uniq_rsp.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_REMAP: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        loaded_count_next = loaded_count_reg;
        res_index_next    = res_index_reg;
        res_new_next      = res_new_reg;
        res_err_next      = res_err_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_index_next      = m_index_reg;
        m_new_next        = m_new_reg;
        m_err_next        = m_err_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    res_index_next = '0;
                    res_new_next   = 1'b0;
                    case (in_kind)
                        KIND_CLEAR: begin
                            res_err_next      = 1'b0;
                            loaded_count_next = '0;
                        end
                        KIND_LOAD:  res_err_next = full;
                        KIND_REMAP: res_err_next = !ep_ok;
                        default:    res_err_next = 1'b1;
                    endcase
                end
            end
            ST_SEARCH: begin
                if (uniq_rsp.done) begin
                    res_index_next    = uniq_rsp.index;
                    res_new_next      = uniq_rsp.fresh;
                    loaded_count_next = loaded_count_reg + 1'b1;
                end
            end
            ST_REMAP: res_index_next = remap_rd_reg;
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_index_next  = res_index_reg;
                    m_new_next    = res_new_reg;
                    m_err_next    = res_err_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            loaded_count_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            loaded_count_reg <= loaded_count_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_index_reg <= res_index_next;
        res_new_reg   <= res_new_next;
        res_err_reg   <= res_err_next;
        m_index_reg   <= m_index_next;
        m_new_reg     <= m_new_next;
        m_err_reg     <= m_err_next;
    end

    // remap table: written at search end, read only by a later request
    always_ff @(posedge aclk) begin
        if (remap_wr_en) begin
            remap_mem[loaded_count_reg[IDX_W-1:0]] <= uniq_rsp.index;
        end
        if (remap_rd_en) begin
            remap_rd_reg <= remap_mem[in_ep];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W-IDX_W){1'b0}}, m_index_reg};
    assign m_tuser  = {m_err_reg, m_new_reg};

    `VDR_NEVER(a_uniq_le_loaded, aclk, aresetn, uniq_rsp.count > loaded_count_reg)
    `VDR_NEVER(a_loaded_cap, aclk, aresetn, loaded_count_reg > CNT_W'(MAX_VERTICES))
    `VDR_NEVER(a_done_in_search, aclk, aresetn, uniq_rsp.done && (state_reg != ST_SEARCH))
    `VDR_ASSERT(a_fresh_appends, aclk, aresetn,
        (uniq_rsp.done && uniq_rsp.fresh) |=> (uniq_rsp.count == $past(uniq_rsp.count) + 1'b1))

endmodule

@@ dv/vertex_dedup_remap_tb.sv @@
// ----------------------------------------------------------------------------
// vertex_dedup_remap_tb
// Self-checking bench: clear, load, remap and bad-kind requests are streamed in, and
// every result is compared with a behavioral copy of the dedup and remap
// tables. Directed corner requests come first, then random traffic under
// changing backpressure and a long output stall.
// ----------------------------------------------------------------------------
module vertex_dedup_remap_tb;
    import vdr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;   // not a legal kind
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int DRAIN_CYCLES  = 50;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_PRINTS    = 40;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [15:0]       x;       // signed coordinate, two's complement
        logic [15:0]       y;
        logic [IDX_W-1:0]  ep;
    } vtx_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] cidx;
        logic             fresh;
        logic             err;
    } dedup_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]   s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;

    vtx_req_t      pend_reqs[$];
    dedup_result_t expected_results[$];

    // behavioral copy of the block state
    logic [WORD_W-1:0] uniq_store [MAX_VERTICES];
    logic [IDX_W-1:0]  remap_tbl  [MAX_VERTICES];
    int                loaded_cnt = 0;
    int                uniq_cnt   = 0;

    int       send_idle_pct = 20;
    int       recv_idle_pct = 80;
    logic     hold_go   = 1'b0;
    int       hold_left = 0;
    int       err_cnt   = 0;
    int       cyc       = 0;
    vtx_req_t cur_req;

    // stimulus-side tracking of what has been loaded since the last clear
    int          gen_loaded = 0;
    logic [31:0] gen_pool[$];

    vertex_dedup_remap u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic vtx_req_t mk_req(logic [KIND_W-1:0] kind, int x, int y, int ep);
        vtx_req_t r;
        r.kind = kind;
        r.x    = x[15:0];
        r.y    = y[15:0];
        r.ep   = ep[IDX_W-1:0];
        return r;
    endfunction

    function automatic int rand_coord();
        int pick;
        pick = $urandom_range(7);
        case (pick)
            0:       return -32768;
            1:       return 32767;
            2:       return -1;
            3:       return 0;
            default: return $urandom_range(65535);
        endcase
    endfunction

    // expected result of one request; updates the table copy
    function automatic dedup_result_t dedup_predict(vtx_req_t r);
        dedup_result_t     res;
        logic [WORD_W-1:0] word;
        int                j;
        res = '0;
        case (r.kind)
            KIND_CLEAR: begin
                loaded_cnt = 0;
                uniq_cnt   = 0;
            end
            KIND_LOAD: begin
                if (loaded_cnt >= MAX_VERTICES) begin
                    res.err = 1'b1;
                end else begin
                    word = {r.y, r.x};
                    j = 0;
                    while (j < uniq_cnt && uniq_store[j] != word) j = j + 1;
                    if (j == uniq_cnt) begin
                        uniq_store[j] = word;
                        uniq_cnt      = uniq_cnt + 1;
                        res.fresh     = 1'b1;
                    end
                    remap_tbl[loaded_cnt] = j[IDX_W-1:0];
                    loaded_cnt = loaded_cnt + 1;
                    res.cidx   = j[IDX_W-1:0];
                end
            end
            KIND_REMAP: begin
                if (int'(r.ep) >= loaded_cnt) res.err = 1'b1;
                else res.cidx = remap_tbl[r.ep];
            end
            default: res.err = 1'b1;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (err_cnt < MAX_PRINTS)
            $display("[%0d] mismatch %s: got %0h expected %0h", cyc, what, got, want);
        err_cnt++;
    endtask

    // driver: request is predicted when it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) expected_results.push_back(dedup_predict(cur_req));
            if (!s_tvalid || s_tready) begin
                if (pend_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req  = pend_reqs.pop_front();
                    s_tdata  <= {4'b0, cur_req.ep, cur_req.y, cur_req.x};
                    s_tuser  <= cur_req.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long output stall, counted on its own
    always @(posedge aclk) begin
        if (hold_go) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge aclk) begin
        dedup_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", int'(m_tdata), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[IDX_W-1:0] != want.cidx)
                        report_mismatch("compact_index", int'(m_tdata[IDX_W-1:0]),
                                        int'(want.cidx));
                    if (m_tuser[0] != want.fresh)
                        report_mismatch("is_new", int'(m_tuser[0]), int'(want.fresh));
                    if (m_tuser[1] != want.err)
                        report_mismatch("error", int'(m_tuser[1]), int'(want.err));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("** vertex_dedup_remap: FAILED **");
            $finish;
        end
    end

    task automatic wait_drain();
        while (pend_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    // mostly well-formed traffic: loads with many duplicates, remaps of
    // loaded indices, some clears, bad kinds and out-of-range remaps
    task automatic gen_random(int n);
        int          pick;
        int          ep;
        logic [31:0] v;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            ep   = $urandom_range(4095);
            if (pick < 45 && gen_loaded < MAX_VERTICES) begin
                if (gen_pool.size() != 0 && $urandom_range(1))
                    v = gen_pool[$urandom_range(gen_pool.size() - 1)];
                else
                    v = {16'(rand_coord()), 16'(rand_coord())};
                gen_pool.push_back(v);
                gen_loaded++;
                pend_reqs.push_back(mk_req(KIND_LOAD, int'(v[15:0]), int'(v[31:16]), ep));
            end else if (pick < 88) begin
                if (gen_loaded != 0 && $urandom_range(99) < 85)
                    ep = $urandom_range(gen_loaded - 1);
                pend_reqs.push_back(mk_req(KIND_REMAP, rand_coord(), rand_coord(), ep));
            end else if (pick < 94) begin
                gen_loaded = 0;
                gen_pool.delete();
                pend_reqs.push_back(mk_req(KIND_CLEAR, rand_coord(), rand_coord(), ep));
            end else begin
                pend_reqs.push_back(mk_req(KIND_BAD, rand_coord(), rand_coord(), ep));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners
        pend_reqs.push_back(mk_req(KIND_CLEAR, 0, 0, 0));
        pend_reqs.push_back(mk_req(KIND_REMAP, 0, 0, 0));            // nothing loaded
        pend_reqs.push_back(mk_req(KIND_LOAD, -32768, -32768, 0));
        pend_reqs.push_back(mk_req(KIND_LOAD, 32767, 32767, 4095));
        pend_reqs.push_back(mk_req(KIND_LOAD, -32768, -32768, 0));   // duplicate
        pend_reqs.push_back(mk_req(KIND_LOAD, 0, 0, 0));
        pend_reqs.push_back(mk_req(KIND_LOAD, -1, 0, 0));
        pend_reqs.push_back(mk_req(KIND_LOAD, 0, -1, 0));
        pend_reqs.push_back(mk_req(KIND_LOAD, 32767, 32767, 0));     // duplicate
        pend_reqs.push_back(mk_req(KIND_REMAP, 0, 0, 2));
        pend_reqs.push_back(mk_req(KIND_REMAP, -1, -1, 6));
        pend_reqs.push_back(mk_req(KIND_REMAP, 0, 0, 7));            // one past loaded
        pend_reqs.push_back(mk_req(KIND_REMAP, 0, 0, 4095));
        pend_reqs.push_back(mk_req(KIND_BAD, 1234, -555, 77));
        pend_reqs.push_back(mk_req(KIND_REMAP, 0, 0, 3));
        pend_reqs.push_back(mk_req(KIND_CLEAR, -1, -1, 4095));
        pend_reqs.push_back(mk_req(KIND_REMAP, 0, 0, 0));            // cleared
        pend_reqs.push_back(mk_req(KIND_LOAD, 32'h5a5a, 32'ha5a5, 0));
        pend_reqs.push_back(mk_req(KIND_LOAD, 1, -32768, 0));
        pend_reqs.push_back(mk_req(KIND_LOAD, 32'h5a5a, 32'ha5a5, 0));
        pend_reqs.push_back(mk_req(KIND_REMAP, 0, 0, 1));
        pend_reqs.push_back(mk_req(KIND_BAD, -1, -1, 4095));
        pend_reqs.push_back(mk_req(KIND_CLEAR, 0, 0, 0));
        gen_random(40);
        wait_drain();

        send_idle_pct = 80;
        recv_idle_pct = 20;
        gen_random(40);
        wait_drain();

        // no idling; output stalls long while requests keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_random(40);
        hold_go = 1'b1;
        @(negedge aclk);
        hold_go = 1'b0;
        wait_drain();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("** vertex_dedup_remap: PASSED **");
        end else begin
            $display("** vertex_dedup_remap: FAILED **");
        end
        $finish;
    end

endmodule
